/* hw/rtl/icmb_pkg.sv */
package icmb_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntWidth  = $clog2(DataWidth + 1);

  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [2:0] {
    OpChoose = 3'd0,
    OpRem    = 3'd1,
    OpAnd    = 3'd2,
    OpOr     = 3'd3,
    OpXor    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrBadArgs  = 3'd1,
    ErrDivZero  = 3'd2,
    ErrOverflow = 3'd3,
    ErrUnknown  = 3'd4
  } err_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture operands, set up first step
    logic div_init; // start a serial divide of num_q by den_q
    logic div_step; // one restoring-divide bit
    logic mul_step; // multiply c by (n - i), widened product
    logic quo_take; // c <= quotient, advance i
    logic finish;   // latch result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       quick;    // result known without iteration
    logic       div_done;
    logic       loop_done;
  } sts_t;

endpackage

/* hw/rtl/icmb_ctrl.sv */
module icmb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  icmb_pkg::sts_t  sts_i,
  output icmb_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDecode= 7'b0000010,
    StMul   = 7'b0000100,
    StChk   = 7'b0001000,
    StDiv   = 7'b0010000,
    StRem   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.quick) begin
          cmd_o.finish = 1'b1;
          state_d = StOut;
        end else if (sts_i.op == icmb_pkg::OpRem) begin
          cmd_o.div_init = 1'b1;
          state_d = StRem;
        end else begin
          cmd_o.mul_step = 1'b1;
          state_d = StChk;
        end
      end
      StMul: begin
        if (sts_i.loop_done) begin
          cmd_o.finish = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.mul_step = 1'b1;
          state_d = StChk;
        end
      end
      // product register settles here before it seeds the divider
      StChk: begin
        cmd_o.div_init = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.quo_take = 1'b1;
          state_d = StMul;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StRem: begin
        if (sts_i.div_done) begin
          cmd_o.finish = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> in_ready_o) else $error("load outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish without result");
`endif

endmodule

/* hw/rtl/icmb_dp.sv */
module icmb_dp (
  input  logic                                      clk_i,
  input  logic [2:0]                                operation_i,
  input  logic signed [icmb_pkg::DataWidth-1:0]     operand_a_i,
  input  logic signed [icmb_pkg::DataWidth-1:0]     operand_b_i,
  input  icmb_pkg::cmd_t                            cmd_i,
  output icmb_pkg::sts_t                            sts_o,
  output logic signed [icmb_pkg::DataWidth-1:0]     value_o,
  output logic [2:0]                                error_code_o
);

  localparam int unsigned W = icmb_pkg::DataWidth;
  localparam int unsigned CW = icmb_pkg::CntWidth;
  localparam logic [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};

  logic [2:0]   op_q;
  logic [W-1:0] a_q, b_q, i_q, c_q;
  logic [2*W-1:0] prod_q;
  logic [W-1:0] quo_q, rem_q, den_q;
  logic         quo_hi_q;
  logic [2*W-1:0] num_q;
  logic [CW:0]  bit_q;
  logic         ovf_q;
  logic [W-1:0] val_q;
  logic [2:0]   err_q;

  // choose uses C(a,i+1) = C(a,i)*(a-i)/(i+1), exact at each step
  logic a_neg, b_neg;
  logic [W-1:0] a_mag, b_mag, nmk, k_min;
  assign a_neg = a_q[W-1];
  assign b_neg = b_q[W-1];
  assign a_mag = a_neg ? (~a_q + 1'b1) : a_q;
  assign b_mag = b_neg ? (~b_q + 1'b1) : b_q;
  assign nmk   = a_q - b_q;
  assign k_min = (nmk < b_q) ? nmk : b_q;

  logic         quick;
  logic [W-1:0] quick_val;
  logic [2:0]   quick_err;
  always_comb begin
    quick = 1'b1;
    quick_val = '0;
    quick_err = icmb_pkg::ErrNone;
    unique case (op_q)
      icmb_pkg::OpChoose: begin
        if (a_neg || b_neg || (b_q > a_q)) begin
          quick_val = '1;
          quick_err = icmb_pkg::ErrBadArgs;
        end else if (a_q == '0 || b_q == '0 || a_q == b_q) begin
          // k equal to 0 or to n leaves no passes to run
          quick_val = {{(W-1){1'b0}}, 1'b1};
        end else begin
          quick = 1'b0;
        end
      end
      icmb_pkg::OpRem: begin
        if (b_q == '0) quick_err = icmb_pkg::ErrDivZero;
        else quick = 1'b0;
      end
      icmb_pkg::OpAnd: quick_val = a_q & b_q;
      icmb_pkg::OpOr:  quick_val = a_q | b_q;
      icmb_pkg::OpXor: quick_val = a_q ^ b_q;
      default:         quick_err = icmb_pkg::ErrUnknown;
    endcase
  end

  // restoring divider, one quotient bit a cycle over 2W-bit numerator
  logic [W:0] trial;
  assign trial = {rem_q, num_q[2*W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      a_q   <= operand_a_i;
      b_q   <= operand_b_i;
      c_q   <= {{(W-1){1'b0}}, 1'b1};
      i_q   <= '0;
      ovf_q <= 1'b0;
    end
    if (cmd_i.mul_step) begin
      prod_q <= (2*W)'(c_q) * (2*W)'(a_q - i_q);
    end
    if (cmd_i.div_init) begin
      rem_q    <= '0;
      quo_q    <= '0;
      quo_hi_q <= 1'b0;
      bit_q    <= '0;
      if (op_q == icmb_pkg::OpRem) begin
        num_q <= {a_mag, {W{1'b0}}};
        den_q <= b_mag;
      end else begin
        num_q <= prod_q;
        den_q <= i_q + 1'b1;
      end
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[2*W-2:0], 1'b0};
      bit_q <= bit_q + 1'b1;
      // a set bit leaving the top means the quotient is past W bits
      if (quo_q[W-1]) quo_hi_q <= 1'b1;
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], num_q[2*W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
    if (cmd_i.quo_take) begin
      c_q <= quo_q;
      i_q <= i_q + 1'b1;
      if (quo_hi_q || quo_q > MaxV) ovf_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      if (quick) begin
        val_q <= quick_val;
        err_q <= quick_err;
      end else if (op_q == icmb_pkg::OpRem) begin
        val_q <= a_neg ? (~rem_q + 1'b1) : rem_q;
        err_q <= icmb_pkg::ErrNone;
      end else if (ovf_q) begin
        val_q <= MaxV;
        err_q <= icmb_pkg::ErrOverflow;
      end else begin
        val_q <= c_q;
        err_q <= icmb_pkg::ErrNone;
      end
    end
  end

  // remainder starts with numerator high half = a_mag; W steps suffice there,
  // choose numerator is 2W bits
  logic [CW:0] steps;
  assign steps = (op_q == icmb_pkg::OpRem) ? (CW+1)'(W) : (CW+1)'(2*W);

  assign sts_o.op        = op_q;
  assign sts_o.quick     = quick;
  assign sts_o.div_done  = (bit_q == steps);
  assign sts_o.loop_done = ovf_q || (i_q == k_min);

  assign value_o      = val_q;
  assign error_code_o = err_q;

endmodule

/* hw/rtl/int_choose_modulo_bitwise_alu_core.sv */
// channel | signals                                              | dir
// in      | in_valid_i/in_ready_o, operation_i, operand_a_i/b_i  | sink
// out     | out_valid_o/out_ready_i, value_o, error_code_o       | source
// One item at a time. Bitwise ops, errors and trivial choose: load, decode, then result.
// Remainder: 32 divide steps plus one to finish, on the shared divider.
// Choose: min(k, n-k) passes, ended early by saturation,
// each pass a multiply and a 64-step exact divide.
// Reset clears the controller only; a held result stalls the input.
module int_choose_modulo_bitwise_alu_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [2:0]                            operation_i,
  input  logic signed [icmb_pkg::DataWidth-1:0] operand_a_i,
  input  logic signed [icmb_pkg::DataWidth-1:0] operand_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [icmb_pkg::DataWidth-1:0] value_o,
  output logic [2:0]                            error_code_o
);

  icmb_pkg::cmd_t cmd;
  icmb_pkg::sts_t sts;

  icmb_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  icmb_dp u_dp (
    .clk_i, .operation_i, .operand_a_i, .operand_b_i,
    .cmd_i(cmd), .sts_o(sts), .value_o, .error_code_o
  );

endmodule
